// ===== rtl/mf3d_pkg.sv =====
// ----------------------------------------------------------------------------
// mf3d_pkg
// Shared types and constants of the clipped 3D median filter.
// ----------------------------------------------------------------------------
package mf3d_pkg;

    localparam int DEF_MAX_X      = 32;
    localparam int DEF_MAX_Y      = 32;
    localparam int DEF_MAX_Z      = 32;
    localparam int DEF_MAX_RADIUS = 2;

    localparam int VOX_W   = 16;
    localparam int COORD_W = 5;
    localparam int SIZE_W  = 6;
    localparam int RAD_W   = 2;
    localparam int CIDX_W  = 8;
    localparam int CDATA_W = 8;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    localparam logic [CIDX_W-1:0] REG_SIZE_X = 8'd0;
    localparam logic [CIDX_W-1:0] REG_SIZE_Y = 8'd1;
    localparam logic [CIDX_W-1:0] REG_SIZE_Z = 8'd2;
    localparam logic [CIDX_W-1:0] REG_RADIUS = 8'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [VOX_W-1:0]  value;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_DRAIN,
        ST_SHIFT,
        ST_RESULT
    } state_t;

endpackage

// ===== rtl/mf3d_ram.sv =====
// ----------------------------------------------------------------------------
// mf3d_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mf3d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mf3d_cell.sv =====
// ----------------------------------------------------------------------------
// mf3d_cell
// One slot of the insertion-sort chain. The chain keeps its valid entries
// sorted ascending from cell 0; shift moves every entry one cell toward 0.
// ----------------------------------------------------------------------------
module mf3d_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mf3d_pkg::cell_ctrl_t                ctrl,
    input  logic signed [mf3d_pkg::VOX_W-1:0]   prev_val,
    input  logic                                prev_gt,
    input  logic                                prev_vld,
    input  logic signed [mf3d_pkg::VOX_W-1:0]   next_val,
    input  logic                                next_vld,
    output logic signed [mf3d_pkg::VOX_W-1:0]   val,
    output logic                                vld,
    output logic                                gt
);

    logic signed [mf3d_pkg::VOX_W-1:0] val_reg, val_next;
    logic                              vld_reg, vld_next;

    // entry is larger than the value being inserted
    assign gt = vld_reg && (val_reg > ctrl.value);

    always_comb begin
        val_next = val_reg;
        vld_next = vld_reg;
        case (ctrl.op)
            mf3d_pkg::CELL_CLEAR: begin
                vld_next = 1'b0;
            end
            mf3d_pkg::CELL_INSERT: begin
                if (prev_gt) begin
                    val_next = prev_val;
                    vld_next = 1'b1;
                end else if (gt || (!vld_reg && prev_vld)) begin
                    // new value lands here: first larger entry or first free slot
                    val_next = ctrl.value;
                    vld_next = 1'b1;
                end
            end
            mf3d_pkg::CELL_SHIFT: begin
                val_next = next_val;
                vld_next = next_vld;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign vld = vld_reg;

endmodule

// ===== rtl/median_filter_3d_clipped_core.sv =====
// ----------------------------------------------------------------------------
// median_filter_3d_clipped_core
// Clipped-window 3D median filter over a voxel volume held in on-chip RAM.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transaction per load or query. s_tuser is the command
//   (load or query), s_tdata carries coordinates and the voxel value.
//   m_ channel: one transaction per query, none per load; m_tdata is the
//   median, m_tuser the status (set when the query lies outside the volume).
//   cfg_ channel: register writes (size_x, size_y, size_z, radius), always
//   ready; write only while the block is idle.
// Sequence:
//   A load writes the RAM on acceptance. A query reads its clipped window
//   from the RAM one voxel per cycle into the sort chain (n voxels, up to
//   125 for a full 5x5x5 window), passes a drain state, shifts the chain
//   toward cell 0 until the middle entry is at the front, then loads the
//   result; an out-of-volume query goes straight to the result. One item
//   is in flight at a time; the single RAM read port sets the fill rate.
// Reset: control state and register defaults (sizes 32, radius 1) are
//   restored; the volume contents are not cleared.
// Stall: a finished result waits in the output register; s_tready stays
//   high meanwhile, so loads and the next query proceed until a second
//   result would need the output register.
// ----------------------------------------------------------------------------
module median_filter_3d_clipped_core #(
    parameter int MAX_X      = mf3d_pkg::DEF_MAX_X,
    parameter int MAX_Y      = mf3d_pkg::DEF_MAX_Y,
    parameter int MAX_Z      = mf3d_pkg::DEF_MAX_Z,
    parameter int MAX_RADIUS = mf3d_pkg::DEF_MAX_RADIUS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [4:0] x_pos, [9:5] y_pos, [14:10] z_pos, [30:15] voxel_value, [31] zero
    input  logic [31:0]                         s_tdata,
    // [0] cmd
    input  logic                                s_tuser,
    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] median_value
    output logic [15:0]                         m_tdata,
    // [0] status
    output logic                                m_tuser,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mf3d_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [mf3d_pkg::CDATA_W-1:0]        cfg_data
);

    localparam int DEPTH   = MAX_X * MAX_Y * MAX_Z;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WIN_CAP = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1)
                             * (2 * MAX_RADIUS + 1);
    localparam int NW      = $clog2(WIN_CAP + 1);
    localparam int VW      = mf3d_pkg::VOX_W;
    localparam int SW      = mf3d_pkg::SIZE_W;

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic [mf3d_pkg::COORD_W-1:0] in_x, in_y, in_z;
    logic signed [VW-1:0]         in_val;

    assign in_x   = s_tdata[4:0];
    assign in_y   = s_tdata[9:5];
    assign in_z   = s_tdata[14:10];
    assign in_val = s_tdata[30:15];

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SW-1:0]                size_x_reg, size_y_reg, size_z_reg;
    logic [mf3d_pkg::RAD_W-1:0]   radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= 6'd32;
            size_y_reg <= 6'd32;
            size_z_reg <= 6'd32;
            radius_reg <= 2'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                mf3d_pkg::REG_SIZE_X: size_x_reg <= cfg_data[SW-1:0];
                mf3d_pkg::REG_SIZE_Y: size_y_reg <= cfg_data[SW-1:0];
                mf3d_pkg::REG_SIZE_Z: size_z_reg <= cfg_data[SW-1:0];
                mf3d_pkg::REG_RADIUS: radius_reg <= cfg_data[mf3d_pkg::RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective sizes and radius, saturated to the build limits
    logic [SW-1:0] eff_sx, eff_sy, eff_sz, eff_r;

    assign eff_sx = (size_x_reg > MAX_X) ? SW'(MAX_X) : size_x_reg;
    assign eff_sy = (size_y_reg > MAX_Y) ? SW'(MAX_Y) : size_y_reg;
    assign eff_sz = (size_z_reg > MAX_Z) ? SW'(MAX_Z) : size_z_reg;
    assign eff_r  = (radius_reg > MAX_RADIUS) ? SW'(MAX_RADIUS) : SW'(radius_reg);

    // ------------------------------------------------------------------
    // Window bounds of the incoming query
    // ------------------------------------------------------------------
    logic [SW-1:0] qx, qy, qz;
    logic [SW-1:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
    logic          q_out;

    assign qx = SW'(in_x);
    assign qy = SW'(in_y);
    assign qz = SW'(in_z);

    assign lo_x = (qx > eff_r) ? qx - eff_r : '0;
    assign lo_y = (qy > eff_r) ? qy - eff_r : '0;
    assign lo_z = (qz > eff_r) ? qz - eff_r : '0;
    assign hi_x = (qx + eff_r < eff_sx) ? qx + eff_r : eff_sx - 6'd1;
    assign hi_y = (qy + eff_r < eff_sy) ? qy + eff_r : eff_sy - 6'd1;
    assign hi_z = (qz + eff_r < eff_sz) ? qz + eff_r : eff_sz - 6'd1;

    assign q_out = (qx >= eff_sx) || (qy >= eff_sy) || (qz >= eff_sz);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    mf3d_pkg::state_t state_reg, state_next;

    logic [SW-1:0] x0_reg, x1_reg, y0_reg, y1_reg, z0_reg, z1_reg;
    logic [SW-1:0] cx_reg, cy_reg, cz_reg;
    logic [SW-1:0] cx_next, cy_next, cz_next;
    logic          err_reg;
    logic          rd_valid_reg;
    logic [NW-1:0] n_reg;
    logic [NW-1:0] sh_reg;
    logic [NW-1:0] sh_target;
    logic          last_rd;
    logic          s_acc, q_acc, ld_acc, out_load;

    logic                 m_valid_reg;
    logic [VW-1:0]        m_data_reg;
    logic                 m_status_reg;

    assign s_tready = (state_reg == mf3d_pkg::ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign q_acc    = s_acc && (s_tuser == mf3d_pkg::CMD_QUERY);
    assign ld_acc   = s_acc && (s_tuser == mf3d_pkg::CMD_LOAD);

    assign last_rd   = (cx_reg == x1_reg) && (cy_reg == y1_reg) && (cz_reg == z1_reg);
    assign sh_target = (n_reg - NW'(1)) >> 1;
    assign out_load  = (state_reg == mf3d_pkg::ST_RESULT) && (!m_valid_reg || m_tready);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mf3d_pkg::ST_IDLE: begin
                if (q_acc) begin
                    state_next = q_out ? mf3d_pkg::ST_RESULT : mf3d_pkg::ST_FILL;
                end
            end
            mf3d_pkg::ST_FILL: begin
                if (last_rd) begin
                    state_next = mf3d_pkg::ST_DRAIN;
                end
            end
            mf3d_pkg::ST_DRAIN: begin
                state_next = mf3d_pkg::ST_SHIFT;
            end
            mf3d_pkg::ST_SHIFT: begin
                if (sh_reg == sh_target) begin
                    state_next = mf3d_pkg::ST_RESULT;
                end
            end
            mf3d_pkg::ST_RESULT: begin
                if (out_load) begin
                    state_next = mf3d_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mf3d_pkg::ST_IDLE;
            end
        endcase
    end

    // window walk, z innermost
    always_comb begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        if (cz_reg == z1_reg) begin
            cz_next = z0_reg;
            if (cy_reg == y1_reg) begin
                cy_next = y0_reg;
                cx_next = cx_reg + 6'd1;
            end else begin
                cy_next = cy_reg + 6'd1;
            end
        end else begin
            cz_next = cz_reg + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mf3d_pkg::ST_IDLE;
            rd_valid_reg <= 1'b0;
            n_reg        <= '0;
            sh_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == mf3d_pkg::ST_FILL);
            if (q_acc) begin
                n_reg <= '0;
            end else if (rd_valid_reg) begin
                n_reg <= n_reg + NW'(1);
            end
            if (state_reg == mf3d_pkg::ST_SHIFT) begin
                sh_reg <= sh_reg + NW'(1);
            end else begin
                sh_reg <= '0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // query context and walk counters
    always_ff @(posedge aclk) begin
        if (q_acc) begin
            x0_reg  <= lo_x;
            x1_reg  <= hi_x;
            y0_reg  <= lo_y;
            y1_reg  <= hi_y;
            z0_reg  <= lo_z;
            z1_reg  <= hi_z;
            cx_reg  <= lo_x;
            cy_reg  <= lo_y;
            cz_reg  <= lo_z;
            err_reg <= q_out;
        end else if (state_reg == mf3d_pkg::ST_FILL) begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            cz_reg <= cz_next;
        end
    end

    // ------------------------------------------------------------------
    // Volume RAM
    // ------------------------------------------------------------------
    logic [31:0]    wr_addr_full, rd_addr_full;
    logic           wr_en;
    logic [VW-1:0]  rd_data;

    assign wr_addr_full = 32'(in_x) + 32'(MAX_X) * (32'(in_y) + 32'(MAX_Y) * 32'(in_z));
    assign rd_addr_full = 32'(cx_reg) + 32'(MAX_X) * (32'(cy_reg) + 32'(MAX_Y) * 32'(cz_reg));
    // loads beyond the store are dropped
    assign wr_en = ld_acc && (in_x < MAX_X) && (in_y < MAX_Y) && (in_z < MAX_Z);

    mf3d_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr_full[AW-1:0]),
        .wr_data (in_val),
        .rd_addr (rd_addr_full[AW-1:0]),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Sort chain
    // ------------------------------------------------------------------
    mf3d_pkg::cell_ctrl_t cell_ctrl;
    logic signed [VW-1:0] cell_val [WIN_CAP];
    logic                 cell_vld [WIN_CAP];
    logic                 cell_gt  [WIN_CAP];

    always_comb begin
        cell_ctrl.value = rd_data;
        if (q_acc) begin
            cell_ctrl.op = mf3d_pkg::CELL_CLEAR;
        end else if (rd_valid_reg) begin
            cell_ctrl.op = mf3d_pkg::CELL_INSERT;
        end else if ((state_reg == mf3d_pkg::ST_SHIFT) && (sh_reg != sh_target)) begin
            cell_ctrl.op = mf3d_pkg::CELL_SHIFT;
        end else begin
            cell_ctrl.op = mf3d_pkg::CELL_HOLD;
        end
    end

    for (genvar i = 0; i < WIN_CAP; i++) begin : g_cell
        logic signed [VW-1:0] p_val, n_val;
        logic                 p_gt, p_vld, n_vld;

        if (i == 0) begin : g_first
            assign p_val = '0;
            assign p_gt  = 1'b0;
            assign p_vld = 1'b1;
        end else begin : g_mid
            assign p_val = cell_val[i-1];
            assign p_gt  = cell_gt[i-1];
            assign p_vld = cell_vld[i-1];
        end

        if (i == WIN_CAP - 1) begin : g_last
            assign n_val = '0;
            assign n_vld = 1'b0;
        end else begin : g_body
            assign n_val = cell_val[i+1];
            assign n_vld = cell_vld[i+1];
        end

        mf3d_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (cell_ctrl),
            .prev_val (p_val),
            .prev_gt  (p_gt),
            .prev_vld (p_vld),
            .next_val (n_val),
            .next_vld (n_vld),
            .val      (cell_val[i]),
            .vld      (cell_vld[i]),
            .gt       (cell_gt[i])
        );
    end

    // ------------------------------------------------------------------
    // Median from the front cell or the two front cells
    // ------------------------------------------------------------------
    logic signed [VW:0]   pair_sum, pair_adj;
    logic signed [VW-1:0] c1_val;
    logic [VW-1:0]        median;

    // with a window of one voxel the second cell is never used
    assign c1_val   = (WIN_CAP > 1) ? cell_val[WIN_CAP > 1 ? 1 : 0] : cell_val[0];
    assign pair_sum = {cell_val[0][VW-1], cell_val[0]} + {c1_val[VW-1], c1_val};
    // round toward zero
    assign pair_adj = pair_sum + ((VW+1)'(pair_sum[VW]));
    assign median   = n_reg[0] ? cell_val[0] : pair_adj[VW:1];

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg   <= err_reg ? '0 : median;
            m_status_reg <= err_reg ? mf3d_pkg::STATUS_ERR : mf3d_pkg::STATUS_OK;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= NW'(WIN_CAP))
        else $error("sort chain overfilled");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error result carries a nonzero median");

    a_rd_from_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> $past(state_reg) == mf3d_pkg::ST_FILL)
        else $error("read data outside window walk");

    a_out_from_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid)
        else $error("result load lost");

endmodule
